>>> design/r12u_pkg.sv
`timescale 1ns / 1ps

package r12u_pkg;

    // Field widths
    localparam int WORD_W   = 32;
    localparam int COMP_W   = 16;
    localparam int RAW_W    = 12;
    localparam int BPL_W    = 11;
    localparam int PAD_W    = 8;
    localparam int LPF_W    = 13;
    localparam int BLOCK_W  = 10;
    localparam int PHASE_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int PIXEL_BITS = 36;
    localparam int ACC_W    = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_LINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_WORDS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINES_PER_FRAME = 2'd2;

    // Register reset values and limits
    localparam logic [BPL_W-1:0] BPL_RESET = 11'd240;
    localparam logic [PAD_W-1:0] PAD_RESET = 8'd0;
    localparam logic [LPF_W-1:0] LPF_RESET = 13'd1080;
    localparam logic [BPL_W-1:0] BPL_MAX   = 11'd1024;

    // Word phases within a block
    localparam logic [PHASE_W-1:0] PHASE_FIRST = 4'd0;
    localparam logic [PHASE_W-1:0] PHASE_ONE   = 4'd1;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 4'd8;
    localparam logic [PHASE_W-1:0] PHASE_PAD   = 4'd9;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [BPL_W-1:0] blocks_per_line;
        logic [PAD_W-1:0] pad_words_per_line;
        logic [LPF_W-1:0] lines_per_frame;
    } cfg_t;

    // One output pixel
    typedef struct packed {
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] red;
        logic              end_of_line;
        logic              end_of_frame;
    } pixel_t;

    // Reverse the byte order of a word
    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // Widen a 12-bit component by bit replication
    function automatic logic [COMP_W-1:0] widen(input logic [RAW_W-1:0] v);
        return {v, v[RAW_W-1:RAW_W-4]};
    endfunction

    // Merge carried bits with the new word placed above them
    function automatic logic [ACC_W-1:0] merge(input logic [WORD_W-1:0]  carry,
                                               input logic [WORD_W-1:0]  s,
                                               input logic [PHASE_W-1:0] phase);
        logic [ACC_W-1:0] wide_s;
        logic [ACC_W-1:0] shifted;
        wide_s = {32'd0, s};
        case (phase)
            4'd1:    shifted = wide_s << 32;
            4'd2:    shifted = wide_s << 28;
            4'd3:    shifted = wide_s << 24;
            4'd4:    shifted = wide_s << 20;
            4'd5:    shifted = wide_s << 16;
            4'd6:    shifted = wide_s << 12;
            4'd7:    shifted = wide_s << 8;
            4'd8:    shifted = wide_s << 4;
            default: shifted = wide_s;
        endcase
        return {32'd0, carry} | shifted;
    endfunction

endpackage

>>> design/r12u_cfg.sv
`timescale 1ns / 1ps

module r12u_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [r12u_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [r12u_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output r12u_pkg::cfg_t                     cfg
);

    logic [r12u_pkg::BPL_W-1:0] bpl_reg;
    logic [r12u_pkg::PAD_W-1:0] pad_reg;
    logic [r12u_pkg::LPF_W-1:0] lpf_reg;

    // Capture register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpl_reg <= r12u_pkg::BPL_RESET;
            pad_reg <= r12u_pkg::PAD_RESET;
            lpf_reg <= r12u_pkg::LPF_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                r12u_pkg::REG_BLOCKS_PER_LINE: bpl_reg <= cfg_wdata[r12u_pkg::BPL_W-1:0];
                r12u_pkg::REG_PAD_WORDS:       pad_reg <= cfg_wdata[r12u_pkg::PAD_W-1:0];
                r12u_pkg::REG_LINES_PER_FRAME: lpf_reg <= cfg_wdata[r12u_pkg::LPF_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp to the usable range
    always_comb
    begin
        if (bpl_reg == '0)
            cfg.blocks_per_line = r12u_pkg::BPL_W'(1);
        else if (bpl_reg > r12u_pkg::BPL_MAX)
            cfg.blocks_per_line = r12u_pkg::BPL_MAX;
        else
            cfg.blocks_per_line = bpl_reg;
        cfg.pad_words_per_line = pad_reg;
        if (lpf_reg == '0)
            cfg.lines_per_frame = r12u_pkg::LPF_W'(1);
        else
            cfg.lines_per_frame = lpf_reg;
    end

endmodule

>>> design/r12u_unpack.sv
`timescale 1ns / 1ps

module r12u_unpack
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            advance,
    input  logic [r12u_pkg::WORD_W-1:0]     word,
    input  r12u_pkg::cfg_t                  cfg,
    output logic                            has_pixel,
    output r12u_pkg::pixel_t                pixel
);

    logic [r12u_pkg::WORD_W-1:0]  carry_reg, carry_next;
    logic [r12u_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [r12u_pkg::BLOCK_W-1:0] block_reg, block_next;
    logic [r12u_pkg::PAD_W-1:0]   pad_reg, pad_next;
    logic [r12u_pkg::LPF_W-1:0]   line_reg, line_next;

    logic [r12u_pkg::WORD_W-1:0]  swapped;
    logic [r12u_pkg::ACC_W-1:0]   acc;
    logic [r12u_pkg::PAD_W-1:0]   pad_sum;
    logic [r12u_pkg::BPL_W-1:0]   block_sum;
    logic [r12u_pkg::LPF_W:0]     line_sum;
    logic                         row_done;
    logic                         frame_done;

    assign swapped   = r12u_pkg::swap_bytes(word);
    assign acc       = r12u_pkg::merge(carry_reg, swapped, phase_reg);
    assign pad_sum   = pad_reg + 1'b1;
    assign block_sum = {1'b0, block_reg} + 1'b1;
    assign line_sum  = {1'b0, line_reg} + 1'b1;
    assign row_done  = (block_sum >= cfg.blocks_per_line);
    assign frame_done = (line_sum >= {1'b0, cfg.lines_per_frame});

    // A pixel completes on phases one to eight
    assign has_pixel = (phase_reg >= r12u_pkg::PHASE_ONE) &&
                       (phase_reg <= r12u_pkg::PHASE_LAST);

    // Build the pixel from the merged bits
    always_comb
    begin
        pixel.red          = r12u_pkg::widen(acc[11:0]);
        pixel.green        = r12u_pkg::widen(acc[23:12]);
        pixel.blue         = r12u_pkg::widen(acc[35:24]);
        pixel.end_of_line  = (phase_reg == r12u_pkg::PHASE_LAST) && row_done;
        pixel.end_of_frame = (phase_reg == r12u_pkg::PHASE_LAST) && row_done &&
                             frame_done;
    end

    // Advance the block, row and frame position
    always_comb
    begin
        carry_next = carry_reg;
        phase_next = phase_reg;
        block_next = block_reg;
        pad_next   = pad_reg;
        line_next  = line_reg;
        if (phase_reg == r12u_pkg::PHASE_PAD)
        begin
            // skip a padding word
            if ((pad_sum >= cfg.pad_words_per_line) || (pad_sum == '0))
            begin
                pad_next   = '0;
                phase_next = r12u_pkg::PHASE_FIRST;
            end
            else
            begin
                pad_next = pad_sum;
            end
        end
        else if ((phase_reg == r12u_pkg::PHASE_FIRST) || (phase_reg > r12u_pkg::PHASE_PAD))
        begin
            carry_next = swapped;
            phase_next = r12u_pkg::PHASE_ONE;
        end
        else
        begin
            carry_next = {4'd0, acc[r12u_pkg::ACC_W-1:r12u_pkg::PIXEL_BITS]};
            if (phase_reg == r12u_pkg::PHASE_LAST)
            begin
                carry_next = '0;
                if (row_done)
                begin
                    line_next  = frame_done ? '0 : line_sum[r12u_pkg::LPF_W-1:0];
                    block_next = '0;
                    pad_next   = '0;
                    phase_next = (cfg.pad_words_per_line != '0) ? r12u_pkg::PHASE_PAD
                                                                : r12u_pkg::PHASE_FIRST;
                end
                else
                begin
                    block_next = block_sum[r12u_pkg::BLOCK_W-1:0];
                    phase_next = r12u_pkg::PHASE_FIRST;
                end
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    // Hold state unless a word moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
            phase_reg <= r12u_pkg::PHASE_FIRST;
            block_reg <= '0;
            pad_reg   <= '0;
            line_reg  <= '0;
        end
        else if (advance)
        begin
            carry_reg <= carry_next;
            phase_reg <= phase_next;
            block_reg <= block_next;
            pad_reg   <= pad_next;
            line_reg  <= line_next;
        end
    end

endmodule

>>> design/r12u_out_reg.sv
`timescale 1ns / 1ps

module r12u_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  r12u_pkg::pixel_t     pixel,
    input  logic                 take,
    output logic                 valid,
    output logic                 free,
    output r12u_pkg::pixel_t     data
);

    logic             valid_reg;
    r12u_pkg::pixel_t data_reg;

    // Slot can be refilled when empty or drained this cycle
    assign free  = !valid_reg || take;
    assign valid = valid_reg;
    assign data  = data_reg;

    // Hold the beat until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= pixel;
        end
    end

endmodule

>>> design/packed_rgb12_to_rgb48_unpacker_top.sv
`timescale 1ns / 1ps

// Packed 12-bit RGB to RGB48 unpacker.
// Input stream: one 32-bit memory word per beat on s_axis. Each row is a run
// of nine-word blocks (eight pixels each) followed by pad_words_per_line
// padding words, which are dropped. Bytes of a word are used from byte 3 down.
// Output stream: one RGB48 pixel per beat on m_axis; tlast marks the last
// pixel of a row and tuser the last pixel of the frame. The first word of each
// block and every padding word give no output beat.
// Pipeline: an accepted word goes through the input register, then the result
// register, from which its pixel is driven on m_axis.
// Throughput: one word per cycle unless stalled (single register-to-register
// pass of the unpack logic); eight pixels leave for every nine block words.
// Stall: when m_axis_tready is low a finished pixel waits in the result
// register; one more word is still taken into the input register, and a word
// that yields no pixel passes through without waiting.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr
// (0 blocks_per_line, 1 pad_words_per_line, 2 lines_per_frame); write only
// while the stream is idle.
// Reset: rst_n clears the position to the first word of the first block of
// the first row, empties both registers and restores the register defaults.
module packed_rgb12_to_rgb48_unpacker_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [r12u_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [r12u_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,   // word_data
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [47:0]                      m_axis_tdata,   // blue, green, red
    output logic                             m_axis_tlast,   // end_of_line
    output logic                             m_axis_tuser    // end_of_frame
);

    r12u_pkg::cfg_t               cfg;
    r12u_pkg::pixel_t             pixel;
    r12u_pkg::pixel_t             out_data;
    logic                         in_valid_reg;
    logic [r12u_pkg::WORD_W-1:0]  in_word_reg;
    logic                         has_pixel;
    logic                         out_free;
    logic                         advance;
    logic                         take;

    r12u_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Move the held word on when its pixel has a place to go
    assign take          = m_axis_tvalid && m_axis_tready;
    assign advance       = in_valid_reg && (!has_pixel || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_word_reg <= s_axis_tdata;
        end
    end

    r12u_unpack u_unpack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .word      (in_word_reg),
        .cfg       (cfg),
        .has_pixel (has_pixel),
        .pixel     (pixel)
    );

    r12u_out_reg u_out_reg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance && has_pixel),
        .pixel (pixel),
        .take  (take),
        .valid (m_axis_tvalid),
        .free  (out_free),
        .data  (out_data)
    );

    // Drive the output beat
    assign m_axis_tdata = {out_data.blue, out_data.green, out_data.red};
    assign m_axis_tlast = out_data.end_of_line;
    assign m_axis_tuser = out_data.end_of_frame;

endmodule
